// ----- rtl/core/ptsu_pkg.sv -----
package ptsu_pkg;

	localparam int KIND_W = 3;
	localparam int COMP_W = 21;
	localparam int AREA_W = 43;
	localparam int MAT_W  = 16;
	localparam int CR_W   = 43;
	localparam int MAG_W  = 42;
	localparam int HALF_W = 21;
	localparam int SUM_W  = 84;
	localparam int ROOT_W = 42;
	localparam int QUOT_W = 16;
	localparam int MUL_W  = 23;
	localparam int PROD_W = 46;

	localparam logic [KIND_W-1:0] KIND_V0  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_V1  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_V2  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_E1  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_E2  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_NRM = 3'd5;

	typedef struct packed {
		logic start;
		logic div;
	} sd_cmd_t;

	typedef struct packed {
		logic done;
		logic root_zero;
	} sd_stat_t;

endpackage

// ----- rtl/core/polygon_fan_triangle_setup_unit.sv -----
// Vertices that open a polygon give no beats.
// A vertex that closes a triangle stalls the input through the cross product multiplies,
// their drain, the squared length multiplies, their drain, the square root and three
// divisions, then six output beats, one per cycle while the sink does not stall.
// A zero cross product skips the divisions and gives a zero normal.
// Async reset (arst_n low) clears the sequencer and vertex count, sets the material to -1.
module polygon_fan_triangle_setup_unit #(
	parameter int COORD_WIDTH = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [COORD_WIDTH-1:0]        vx,
	input  logic signed [COORD_WIDTH-1:0]        vy,
	input  logic signed [COORD_WIDTH-1:0]        vz,
	input  logic                                 first_vertex,
	input  logic signed [ptsu_pkg::MAT_W-1:0]    material_id,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ptsu_pkg::KIND_W-1:0]          vector_kind,
	output logic signed [ptsu_pkg::COMP_W-1:0]   comp_x,
	output logic signed [ptsu_pkg::COMP_W-1:0]   comp_y,
	output logic signed [ptsu_pkg::COMP_W-1:0]   comp_z,
	output logic [ptsu_pkg::AREA_W-1:0]          tri_area,
	output logic signed [ptsu_pkg::MAT_W-1:0]    tri_material,
	output logic                                 last_of_triangle
);
	import ptsu_pkg::*;

	localparam int EW = COORD_WIDTH + 1;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_CROSS  = 9'b000000010,
		S_MAG    = 9'b000000100,
		S_SQUARE = 9'b000001000,
		S_RSTART = 9'b000010000,
		S_RWAIT  = 9'b000100000,
		S_DSTART = 9'b001000000,
		S_DWAIT  = 9'b010000000,
		S_OUT    = 9'b100000000
	} state_t;

	state_t state_q;

	logic signed [COORD_WIDTH-1:0] vin [3];
	logic signed [COORD_WIDTH-1:0] org_q [3];
	logic signed [COORD_WIDTH-1:0] prv_q [3];
	logic signed [COORD_WIDTH-1:0] cur_q [3];
	logic signed [COMP_W-1:0]      e1_q [3];
	logic signed [COMP_W-1:0]      e2_q [3];
	logic signed [COMP_W-1:0]      nrm_q [3];
	logic signed [CR_W-1:0]        cr_q [3];
	logic [MAG_W-1:0]              mag_q [3];
	logic [SUM_W-1:0]              sum_q;
	logic [1:0]                    vcnt_q;
	logic signed [MAT_W-1:0]       mat_q;
	logic [1:0]                    comp_q, part_q;
	logic [KIND_W-1:0]             kidx_q;

	logic                          tag_vld_s1, tag_sq_s1;
	logic [1:0]                    tag_comp_s1, tag_part_s1;

	logic signed [MUL_W-1:0]       ma, mb;
	logic signed [PROD_W-1:0]      p_s1;
	logic [HALF_W-1:0]             mhi, mlo;
	logic                          mul_go, last_issue;
	logic                          acc;
	logic signed [EW-1:0]          d1 [3];
	logic signed [EW-1:0]          d2 [3];

	sd_cmd_t                       sd_cmd;
	sd_stat_t                      sd_stat;
	logic [ROOT_W-1:0]             root;
	logic [QUOT_W-1:0]             quot;

	logic                          out_vld_q;
	logic                          out_load;
	logic [KIND_W-1:0]             kind_q;
	logic signed [COMP_W-1:0]      ox_q, oy_q, oz_q;
	logic [AREA_W-1:0]             area_q;
	logic signed [MAT_W-1:0]       omat_q;

	assign vin[0] = vx;
	assign vin[1] = vy;
	assign vin[2] = vz;

	assign in_stall = (state_q != S_IDLE);
	assign acc      = in_valid && (state_q == S_IDLE);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d1[i] = EW'(prv_q[i]) - EW'(org_q[i]);
			d2[i] = EW'(vin[i]) - EW'(org_q[i]);
		end
	end

	// operand selection for the shared multiplier
	always_comb begin
		mhi = mag_q[comp_q][MAG_W-1:HALF_W];
		mlo = mag_q[comp_q][HALF_W-1:0];
		if (state_q == S_CROSS) begin
			case (comp_q)
				2'd0: begin
					ma = MUL_W'(part_q[0] ? e1_q[2] : e1_q[1]);
					mb = MUL_W'(part_q[0] ? e2_q[1] : e2_q[2]);
				end
				2'd1: begin
					ma = MUL_W'(part_q[0] ? e1_q[0] : e1_q[2]);
					mb = MUL_W'(part_q[0] ? e2_q[2] : e2_q[0]);
				end
				default: begin
					ma = MUL_W'(part_q[0] ? e1_q[1] : e1_q[0]);
					mb = MUL_W'(part_q[0] ? e2_q[0] : e2_q[1]);
				end
			endcase
		end else begin
			// |c|^2 = hi^2 << 42 + 2 hi lo << 21 + lo^2
			ma = signed'({2'b00, (part_q == 2'd2) ? mlo : mhi});
			mb = signed'({2'b00, (part_q == 2'd0) ? mhi : mlo});
		end
	end

	assign mul_go     = (state_q == S_CROSS) || (state_q == S_SQUARE);
	assign last_issue = (comp_q == 2'd2) &&
	                    (part_q == ((state_q == S_CROSS) ? 2'd1 : 2'd2));

	ptsu_mul u_mul (
		.clk  (clk),
		.a    (ma),
		.b    (mb),
		.p_s1 (p_s1)
	);

	always_comb begin
		sd_cmd.start = 1'b0;
		sd_cmd.div   = 1'b0;
		if (state_q == S_RSTART && !tag_vld_s1) begin
			sd_cmd.start = 1'b1;
		end else if (state_q == S_DSTART && !sd_stat.root_zero) begin
			sd_cmd.start = 1'b1;
			sd_cmd.div   = 1'b1;
		end
	end

	ptsu_sqdiv u_sqdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (sd_cmd),
		.radicand (sum_q),
		.mag      (mag_q[comp_q]),
		.root     (root),
		.quot     (quot),
		.stat     (sd_stat)
	);

	assign out_load = (state_q == S_OUT) && (!out_vld_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			vcnt_q     <= '0;
			mat_q      <= '1;
			tag_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
			comp_q     <= '0;
			part_q     <= '0;
			kidx_q     <= '0;
		end else begin
			tag_vld_s1 <= mul_go;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (first_vertex || vcnt_q == 2'd0) begin
							vcnt_q <= 2'd1;
							mat_q  <= material_id;
						end else if (vcnt_q == 2'd1) begin
							vcnt_q <= 2'd2;
						end else begin
							comp_q  <= '0;
							part_q  <= '0;
							state_q <= S_CROSS;
						end
					end
				end
				S_CROSS, S_SQUARE: begin
					if (last_issue) begin
						comp_q  <= '0;
						part_q  <= '0;
						state_q <= (state_q == S_CROSS) ? S_MAG : S_RSTART;
					end else if (part_q == ((state_q == S_CROSS) ? 2'd1 : 2'd2)) begin
						part_q <= '0;
						comp_q <= comp_q + 2'd1;
					end else begin
						part_q <= part_q + 2'd1;
					end
				end
				S_MAG: begin
					if (!tag_vld_s1) begin
						state_q <= S_SQUARE;
					end
				end
				S_RSTART: begin
					if (!tag_vld_s1) begin
						state_q <= S_RWAIT;
					end
				end
				S_RWAIT: begin
					if (sd_stat.done) begin
						comp_q  <= '0;
						state_q <= S_DSTART;
					end
				end
				S_DSTART: begin
					if (!sd_stat.root_zero) begin
						state_q <= S_DWAIT;
					end else if (comp_q == 2'd2) begin
						kidx_q  <= KIND_V0;
						state_q <= S_OUT;
					end else begin
						comp_q <= comp_q + 2'd1;
					end
				end
				S_DWAIT: begin
					if (sd_stat.done) begin
						if (comp_q == 2'd2) begin
							kidx_q  <= KIND_V0;
							state_q <= S_OUT;
						end else begin
							comp_q  <= comp_q + 2'd1;
							state_q <= S_DSTART;
						end
					end
				end
				S_OUT: begin
					if (out_load) begin
						kidx_q <= kidx_q + 3'd1;
						if (kidx_q == KIND_NRM) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		tag_sq_s1   <= (state_q == S_SQUARE);
		tag_comp_s1 <= comp_q;
		tag_part_s1 <= part_q;

		if (acc) begin
			for (int i = 0; i < 3; i++) begin
				if (first_vertex || vcnt_q == 2'd0) begin
					org_q[i] <= vin[i];
					prv_q[i] <= vin[i];
				end else if (vcnt_q == 2'd1) begin
					prv_q[i] <= vin[i];
				end else begin
					cur_q[i] <= vin[i];
					e1_q[i]  <= COMP_W'(d1[i]);
					e2_q[i]  <= COMP_W'(d2[i]);
				end
			end
		end

		if (tag_vld_s1) begin
			if (!tag_sq_s1) begin
				if (tag_part_s1 == 2'd0) begin
					cr_q[tag_comp_s1] <= CR_W'(p_s1);
				end else begin
					cr_q[tag_comp_s1] <= cr_q[tag_comp_s1] - CR_W'(p_s1);
				end
			end else begin
				case (tag_part_s1)
					2'd0:    sum_q <= sum_q + (SUM_W'(p_s1[2*HALF_W-1:0]) << (2*HALF_W));
					2'd1:    sum_q <= sum_q + (SUM_W'(p_s1[2*HALF_W-1:0]) << (HALF_W+1));
					default: sum_q <= sum_q + SUM_W'(p_s1[2*HALF_W-1:0]);
				endcase
			end
		end

		if (state_q == S_MAG && !tag_vld_s1) begin
			sum_q <= '0;
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= MAG_W'(cr_q[i][CR_W-1] ? -cr_q[i] : cr_q[i]);
			end
		end

		if (state_q == S_DSTART && sd_stat.root_zero) begin
			nrm_q[comp_q] <= '0;
		end
		if (state_q == S_DWAIT && sd_stat.done) begin
			nrm_q[comp_q] <= cr_q[comp_q][CR_W-1] ? -COMP_W'(quot) : COMP_W'(quot);
		end

		if (out_load) begin
			kind_q <= kidx_q;
			// area and material held with the beat, the next vertex may change them
			area_q <= AREA_W'(root >> 1);
			omat_q <= mat_q;
			case (kidx_q)
				KIND_V0: begin
					ox_q <= COMP_W'(org_q[0]);
					oy_q <= COMP_W'(org_q[1]);
					oz_q <= COMP_W'(org_q[2]);
				end
				KIND_V1: begin
					ox_q <= COMP_W'(prv_q[0]);
					oy_q <= COMP_W'(prv_q[1]);
					oz_q <= COMP_W'(prv_q[2]);
				end
				KIND_V2: begin
					ox_q <= COMP_W'(cur_q[0]);
					oy_q <= COMP_W'(cur_q[1]);
					oz_q <= COMP_W'(cur_q[2]);
				end
				KIND_E1: begin
					ox_q <= e1_q[0];
					oy_q <= e1_q[1];
					oz_q <= e1_q[2];
				end
				KIND_E2: begin
					ox_q <= e2_q[0];
					oy_q <= e2_q[1];
					oz_q <= e2_q[2];
				end
				default: begin
					ox_q <= nrm_q[0];
					oy_q <= nrm_q[1];
					oz_q <= nrm_q[2];
				end
			endcase
			if (kidx_q == KIND_NRM) begin
				for (int i = 0; i < 3; i++) begin
					prv_q[i] <= cur_q[i];
				end
			end
		end
	end

	assign out_valid        = out_vld_q;
	assign vector_kind      = kind_q;
	assign comp_x           = ox_q;
	assign comp_y           = oy_q;
	assign comp_z           = oz_q;
	assign tri_area         = area_q;
	assign tri_material     = omat_q;
	assign last_of_triangle = (kind_q == KIND_NRM);

endmodule

// ----- rtl/core/ptsu_mul.sv -----
module ptsu_mul (
	input  logic                                clk,
	input  logic signed [ptsu_pkg::MUL_W-1:0]   a,
	input  logic signed [ptsu_pkg::MUL_W-1:0]   b,
	output logic signed [ptsu_pkg::PROD_W-1:0]  p_s1
);
	import ptsu_pkg::*;

	logic signed [PROD_W-1:0] prod;

	assign prod = PROD_W'(a) * PROD_W'(b);

	always_ff @(posedge clk) begin
		p_s1 <= prod;
	end

endmodule

// ----- rtl/core/ptsu_sqdiv.sv -----
// Shared subtract/compare unit: square root two bits of radicand per step,
// division one quotient bit per step.
module ptsu_sqdiv (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ptsu_pkg::sd_cmd_t                 cmd,
	input  logic [ptsu_pkg::SUM_W-1:0]        radicand,
	input  logic [ptsu_pkg::MAG_W-1:0]        mag,
	output logic [ptsu_pkg::ROOT_W-1:0]       root,
	output logic [ptsu_pkg::QUOT_W-1:0]       quot,
	output ptsu_pkg::sd_stat_t                stat
);
	import ptsu_pkg::*;

	localparam int OPW   = 47;
	localparam int REM_W = 45;
	localparam int NUM_W = 58;
	localparam logic [5:0] SQRT_STEPS = 6'(SUM_W / 2);
	localparam logic [5:0] DIV_STEPS  = 6'(QUOT_W);

	logic              busy_q, div_q, done_q;
	logic [5:0]        cnt_q;
	logic [SUM_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [QUOT_W-1:0] quot_q;
	logic [OPW-1:0]    opa, opb;
	logic [OPW:0]      diff;
	logic              ge;
	logic [NUM_W-1:0]  num;

	always_comb begin
		if (div_q) begin
			opa = {1'b0, rem_q, rad_q[SUM_W-1]};
			opb = OPW'(root_q);
		end else begin
			opa = {rem_q, rad_q[SUM_W-1 -: 2]};
			opb = OPW'({root_q, 2'b01});
		end
		diff = {1'b0, opa} - {1'b0, opb};
		ge   = !diff[OPW];
		num  = NUM_W'({mag, 15'b0}) + NUM_W'(root_q >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			div_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				div_q  <= cmd.div;
				cnt_q  <= cmd.div ? DIV_STEPS : SQRT_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			if (cmd.div) begin
				rem_q                       <= REM_W'(num[NUM_W-1:QUOT_W]);
				rad_q[SUM_W-1 -: QUOT_W]    <= num[QUOT_W-1:0];
				quot_q                      <= '0;
			end else begin
				rad_q  <= radicand;
				rem_q  <= '0;
				root_q <= '0;
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff[REM_W-1:0] : opa[REM_W-1:0];
			if (div_q) begin
				rad_q  <= rad_q << 1;
				quot_q <= {quot_q[QUOT_W-2:0], ge};
			end else begin
				rad_q  <= rad_q << 2;
				root_q <= {root_q[ROOT_W-2:0], ge};
			end
		end
	end

	assign root           = root_q;
	assign quot           = quot_q;
	assign stat.done      = done_q;
	assign stat.root_zero = (root_q == '0);

endmodule
